// File: design/wpp_pkg.sv
`timescale 1ns / 1ps

package wpp_pkg;

    localparam int MAX_SAMPLE_BYTES = 4;

    localparam logic [31:0] ID_RIFF = 32'h4646_4952;
    localparam logic [31:0] ID_WAVE = 32'h4556_4157;
    localparam logic [31:0] ID_FMT  = 32'h2074_6D66;
    localparam logic [31:0] ID_DATA = 32'h6174_6164;

    typedef enum logic [7:0] {
        ST_RIFF  = 8'b0000_0001,
        ST_CHUNK = 8'b0000_0010,
        ST_FMT   = 8'b0000_0100,
        ST_SKIP  = 8'b0000_1000,
        ST_DATA  = 8'b0001_0000,
        ST_DONE  = 8'b0010_0000,
        ST_DIV   = 8'b0100_0000,
        ST_ERR   = 8'b1000_0000
    } t_state;

    typedef enum logic [1:0] {
        KIND_FMT    = 2'd0,
        KIND_SAMPLE = 2'd1,
        KIND_ERR    = 2'd2,
        KIND_EOS    = 2'd3
    } t_kind;

    typedef enum logic [3:0] {
        ERR_NONE       = 4'd0,
        ERR_EARLY_END  = 4'd1,
        ERR_RIFF_ID    = 4'd2,
        ERR_WAVE_ID    = 4'd3,
        ERR_FMT_SHORT  = 4'd4,
        ERR_NOT_PCM    = 4'd5,
        ERR_NO_CHAN    = 4'd6,
        ERR_ALIGN_ZERO = 4'd7,
        ERR_BITS_LOW   = 4'd8,
        ERR_BITS_HIGH  = 4'd9,
        ERR_ALIGN_BAD  = 4'd10,
        ERR_TOO_WIDE   = 4'd11,
        ERR_NO_FMT     = 4'd12,
        ERR_DATA_SIZE  = 4'd13
    } t_err;

    typedef enum logic [1:0] {
        SEL_BYTE = 2'd0,
        SEL_FMT  = 2'd1,
        SEL_EOS  = 2'd2,
        SEL_ERR  = 2'd3
    } t_sel;

    typedef struct packed {
        t_kind              kind;
        t_err               error_code;
        logic signed [31:0] sample_value;
        logic [15:0]        channel_index;
        logic               frame_end;
        logic               data_end;
        logic [15:0]        channel_count;
        logic [31:0]        sample_rate;
        logic [6:0]         bits_per_sample;
        logic [31:0]        frame_total;
    } t_result;

    typedef struct packed {
        t_state state;
        logic   take;
        logic   clear;
        logic   div_start;
        logic   data_start;
        logic   load;
        t_sel   sel;
        t_err   code;
    } t_cmd;

    typedef struct packed {
        logic   has_res;
        logic   is_err;
        t_state nxt;
        logic   div_req;
        logic   div_done;
        logic   rem_zero;
        logic   quo_zero;
    } t_status;

    function automatic logic [31:0] put_le(logic [31:0] word, logic [1:0] pos,
                                           logic [7:0] b);
        logic [31:0] w;
        w = word;
        case (pos)
            2'd0: w[7:0]   = b;
            2'd1: w[15:8]  = b;
            2'd2: w[23:16] = b;
            2'd3: w[31:24] = b;
            default: w = word;
        endcase
        return w;
    endfunction

endpackage

// File: design/wpp_if.sv
`timescale 1ns / 1ps

interface wpp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_value;
    logic       stream_end;

    modport source(output valid, output byte_value, output stream_end, input ready);
    modport sink(input valid, input byte_value, input stream_end, output ready);
endinterface

interface wpp_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         kind;
    logic [3:0]         error_code;
    logic signed [31:0] sample_value;
    logic [15:0]        channel_index;
    logic               frame_end;
    logic               data_end;
    logic [15:0]        channel_count;
    logic [31:0]        sample_rate;
    logic [6:0]         bits_per_sample;
    logic [31:0]        frame_total;

    modport source(output valid, output kind, output error_code, output sample_value,
                   output channel_index, output frame_end, output data_end,
                   output channel_count, output sample_rate, output bits_per_sample,
                   output frame_total, input ready);
    modport sink(input valid, input kind, input error_code, input sample_value,
                 input channel_index, input frame_end, input data_end,
                 input channel_count, input sample_rate, input bits_per_sample,
                 input frame_total, output ready);
endinterface

// File: design/wpp_div.sv
`timescale 1ns / 1ps

module wpp_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_dividend,
    input  logic [15:0] i_divisor,
    output logic        o_done,
    output logic [31:0] o_quotient,
    output logic [15:0] o_remainder
);
    logic        r_busy;
    logic        r_done;
    logic [4:0]  r_cnt;
    logic [31:0] r_quo;
    logic [15:0] r_rem;
    logic [15:0] r_dvs;
    logic [16:0] sh;
    logic [17:0] diff;
    logic        ge;

    assign sh   = {r_rem, r_quo[31]};
    assign diff = {1'b0, sh} - {2'b00, r_dvs};
    assign ge   = !diff[17];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[30:0], ge};
            r_rem <= ge ? diff[15:0] : sh[15:0];
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;
endmodule

// File: design/wpp_dp.sv
`timescale 1ns / 1ps

module wpp_dp (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [7:0]       i_byte,
    input  wpp_pkg::t_cmd    i_cmd,
    output wpp_pkg::t_status o_status,
    output wpp_pkg::t_result o_result
);
    import wpp_pkg::*;

    logic [3:0]  r_idx,   n_idx;
    logic [31:0] r_shift, n_shift;
    logic [32:0] r_len,   n_len;
    logic [15:0] r_fcode, n_fcode;
    logic [15:0] r_nch,   n_nch;
    logic [31:0] r_rate,  n_rate;
    logic [15:0] r_align, n_align;
    logic [15:0] r_vbits, n_vbits;
    logic [2:0]  r_sbytes, n_sbytes;
    logic [31:0] r_accum, n_accum;
    logic [15:0] r_chan,  n_chan;
    logic [31:0] r_frames, n_frames;
    logic        r_fseen, n_fseen;
    t_result     r_out,   n_out;
    t_result     res;

    logic        has_res, is_err, div_req;
    t_state      nxt;
    logic [31:0] size;
    logic [32:0] padded;
    logic [7:0]  vb7;
    logic [3:0]  nb;
    logic [19:0] prod;
    logic [2:0]  snb;
    logic [31:0] v;
    logic        fe, de;

    logic        div_done;
    logic [31:0] quo;
    logic [15:0] rem;

    wpp_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (n_len[31:0]),
        .i_divisor  (r_align),
        .o_done     (div_done),
        .o_quotient (quo),
        .o_remainder(rem)
    );

    always_comb begin
        n_idx = r_idx; n_shift = r_shift; n_len = r_len; n_fcode = r_fcode;
        n_nch = r_nch; n_rate = r_rate; n_align = r_align; n_vbits = r_vbits;
        n_sbytes = r_sbytes; n_accum = r_accum; n_chan = r_chan;
        n_frames = r_frames; n_fseen = r_fseen;
        res = '0; has_res = 1'b0; is_err = 1'b0; div_req = 1'b0;
        nxt = i_cmd.state;
        size = '0; padded = '0; vb7 = '0; nb = '0; prod = '0; snb = '0;
        v = '0; fe = 1'b0; de = 1'b0;
        case (i_cmd.state)
            ST_RIFF: begin
                if (r_idx < 4'd4 || r_idx >= 4'd8)
                    n_shift = put_le(r_shift, r_idx[1:0], i_byte);
                n_idx = r_idx + 4'd1;
                if (r_idx == 4'd3 && n_shift != ID_RIFF) begin
                    is_err = 1'b1; res.error_code = ERR_RIFF_ID;
                end
                if (r_idx == 4'd11) begin
                    if (n_shift != ID_WAVE) begin
                        is_err = 1'b1; res.error_code = ERR_WAVE_ID;
                    end else begin
                        n_idx = '0;
                        nxt   = ST_CHUNK;
                    end
                end
            end
            ST_CHUNK: begin
                if (r_idx < 4'd4) n_shift = put_le(r_shift, r_idx[1:0], i_byte);
                else n_len = {1'b0, put_le(r_len[31:0], r_idx[1:0], i_byte)};
                n_idx = r_idx + 4'd1;
                if (r_idx == 4'd7) begin
                    n_idx  = '0;
                    size   = n_len[31:0];
                    padded = {1'b0, size} + {32'd0, size[0]};
                    if (n_shift == ID_FMT) begin
                        if (size < 32'd16) begin
                            is_err = 1'b1; res.error_code = ERR_FMT_SHORT;
                        end else begin
                            n_len = padded - 33'd16;
                            nxt   = ST_FMT;
                        end
                    end else if (n_shift == ID_DATA) begin
                        if (!r_fseen) begin
                            is_err = 1'b1; res.error_code = ERR_NO_FMT;
                        end else begin
                            div_req = 1'b1;
                        end
                    end else begin
                        n_len = padded;
                        nxt   = (padded != 33'd0) ? ST_SKIP : ST_CHUNK;
                    end
                end
            end
            ST_FMT: begin
                case (r_idx)
                    4'd0:  n_fcode[7:0]   = i_byte;
                    4'd1:  n_fcode[15:8]  = i_byte;
                    4'd2:  n_nch[7:0]     = i_byte;
                    4'd3:  n_nch[15:8]    = i_byte;
                    4'd4:  n_rate[7:0]    = i_byte;
                    4'd5:  n_rate[15:8]   = i_byte;
                    4'd6:  n_rate[23:16]  = i_byte;
                    4'd7:  n_rate[31:24]  = i_byte;
                    4'd12: n_align[7:0]   = i_byte;
                    4'd13: n_align[15:8]  = i_byte;
                    4'd14: n_vbits[7:0]   = i_byte;
                    4'd15: n_vbits[15:8]  = i_byte;
                    default: n_idx = n_idx;
                endcase
                n_idx = r_idx + 4'd1;
                if (r_idx == 4'd15) begin
                    n_idx = '0;
                    vb7   = {1'b0, n_vbits[6:0]} + 8'd7;
                    nb    = vb7[6:3];
                    prod  = {16'd0, nb} * {4'd0, n_nch};
                    if (n_fcode != 16'd1) begin
                        is_err = 1'b1; res.error_code = ERR_NOT_PCM;
                    end else if (n_nch == 16'd0) begin
                        is_err = 1'b1; res.error_code = ERR_NO_CHAN;
                    end else if (n_align == 16'd0) begin
                        is_err = 1'b1; res.error_code = ERR_ALIGN_ZERO;
                    end else if (n_vbits < 16'd2) begin
                        is_err = 1'b1; res.error_code = ERR_BITS_LOW;
                    end else if (n_vbits > 16'd64) begin
                        is_err = 1'b1; res.error_code = ERR_BITS_HIGH;
                    end else if (prod != {4'd0, n_align}) begin
                        is_err = 1'b1; res.error_code = ERR_ALIGN_BAD;
                    end else if (nb > 4'(MAX_SAMPLE_BYTES)) begin
                        is_err = 1'b1; res.error_code = ERR_TOO_WIDE;
                    end else begin
                        n_sbytes = nb[2:0];
                        n_fseen  = 1'b1;
                        nxt      = (r_len != 33'd0) ? ST_SKIP : ST_CHUNK;
                    end
                end
            end
            ST_SKIP: begin
                if (r_len != 33'd0) n_len = r_len - 33'd1;
                if (n_len == 33'd0) begin
                    nxt   = ST_CHUNK;
                    n_idx = '0;
                end
            end
            ST_DATA: begin
                snb     = (r_sbytes != 3'd0) ? r_sbytes : 3'd1;
                n_accum = put_le(r_accum, r_idx[1:0], i_byte);
                if (({1'b0, r_idx} + 5'd1) < {2'b00, snb}) begin
                    n_idx = r_idx + 4'd1;
                end else begin
                    n_idx = '0;
                    v     = n_accum;
                    if (i_byte[7] && snb == 3'd2) v[31:16] = '1;
                    if (i_byte[7] && snb == 3'd3) v[31:24] = '1;
                    n_accum = '0;
                    fe = ({1'b0, r_chan} + 17'd1) >= {1'b0, r_nch};
                    de = fe && (r_frames[31:1] == 31'd0);
                    has_res           = 1'b1;
                    res.kind          = KIND_SAMPLE;
                    res.sample_value  = v;
                    res.channel_index = r_chan;
                    res.frame_end     = fe;
                    res.data_end      = de;
                    if (fe) begin
                        n_chan = '0;
                        if (r_frames != 32'd0) n_frames = r_frames - 32'd1;
                    end else begin
                        n_chan = r_chan + 16'd1;
                    end
                    if (de) nxt = ST_DONE;
                end
            end
            default: nxt = i_cmd.state;
        endcase
        if (is_err) begin
            has_res  = 1'b1;
            res.kind = KIND_ERR;
        end
    end

    always_comb begin
        n_out = '0;
        case (i_cmd.sel)
            SEL_BYTE: n_out = res;
            SEL_FMT: begin
                n_out.kind            = KIND_FMT;
                n_out.channel_count   = r_nch;
                n_out.sample_rate     = r_rate;
                n_out.bits_per_sample = r_vbits[6:0];
                n_out.frame_total     = quo;
            end
            SEL_EOS: n_out.kind = KIND_EOS;
            SEL_ERR: begin
                n_out.kind       = KIND_ERR;
                n_out.error_code = i_cmd.code;
            end
            default: n_out = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.clear) begin
            r_idx   <= '0;
            r_len   <= '0;
            r_fseen <= 1'b0;
        end else if (i_cmd.take) begin
            r_idx   <= n_idx;
            r_len   <= n_len;
            r_fseen <= n_fseen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_shift  <= n_shift;
            r_fcode  <= n_fcode;
            r_nch    <= n_nch;
            r_rate   <= n_rate;
            r_align  <= n_align;
            r_vbits  <= n_vbits;
            r_sbytes <= n_sbytes;
            r_accum  <= n_accum;
            r_chan   <= n_chan;
            r_frames <= n_frames;
        end else if (i_cmd.data_start) begin
            r_frames <= quo;
            r_chan   <= '0;
            r_accum  <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out <= n_out;
        end
    end

    assign o_status.has_res  = has_res;
    assign o_status.is_err   = is_err;
    assign o_status.nxt      = nxt;
    assign o_status.div_req  = div_req;
    assign o_status.div_done = div_done;
    assign o_status.rem_zero = (rem == 16'd0);
    assign o_status.quo_zero = (quo == 32'd0);
    assign o_result = r_out;
endmodule

// File: design/wpp_ctrl.sv
`timescale 1ns / 1ps

module wpp_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_last,
    input  logic             i_out_ready,
    input  wpp_pkg::t_status i_status,
    output logic             o_in_ready,
    output logic             o_out_valid,
    output wpp_pkg::t_cmd    o_cmd
);
    import wpp_pkg::*;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   r_last, n_last;
    logic   in_ready, accept;
    t_cmd   cmd;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_last      = r_last;
        cmd         = '0;
        cmd.state   = r_state;
        cmd.sel     = SEL_BYTE;
        cmd.code    = ERR_NONE;
        in_ready    = (r_state != ST_DIV) && (!r_out_valid || i_out_ready);
        accept      = i_in_valid && in_ready;
        if (r_out_valid && i_out_ready) n_out_valid = 1'b0;

        if (r_state == ST_DIV) begin
            if (i_status.div_done) begin
                cmd.load = 1'b1;
                if (!i_status.rem_zero) begin
                    cmd.sel  = SEL_ERR;
                    cmd.code = ERR_DATA_SIZE;
                    if (r_last) begin
                        cmd.clear = 1'b1;
                        n_state   = ST_RIFF;
                    end else begin
                        n_state = ST_ERR;
                    end
                end else if (r_last) begin
                    cmd.clear = 1'b1;
                    n_state   = ST_RIFF;
                    if (i_status.quo_zero) begin
                        cmd.sel = SEL_FMT;
                    end else begin
                        cmd.sel  = SEL_ERR;
                        cmd.code = ERR_EARLY_END;
                    end
                end else begin
                    cmd.sel        = SEL_FMT;
                    cmd.data_start = 1'b1;
                    n_state        = i_status.quo_zero ? ST_DONE : ST_DATA;
                end
            end
        end else if (accept) begin
            if (r_state == ST_ERR) begin
                if (i_in_last) begin
                    cmd.clear = 1'b1;
                    n_state   = ST_RIFF;
                end
            end else begin
                cmd.take = 1'b1;
                if (i_status.has_res && i_status.is_err) begin
                    cmd.load = 1'b1;
                    if (i_in_last) begin
                        cmd.clear = 1'b1;
                        n_state   = ST_RIFF;
                    end else begin
                        n_state = ST_ERR;
                    end
                end else if (i_status.div_req) begin
                    cmd.div_start = 1'b1;
                    n_last        = i_in_last;
                    n_state       = ST_DIV;
                end else if (i_in_last) begin
                    cmd.clear = 1'b1;
                    cmd.load  = 1'b1;
                    n_state   = ST_RIFF;
                    if (i_status.nxt != ST_DONE) begin
                        cmd.sel  = SEL_ERR;
                        cmd.code = ERR_EARLY_END;
                    end else if (!i_status.has_res) begin
                        cmd.sel = SEL_EOS;
                    end
                end else begin
                    cmd.load = i_status.has_res;
                    n_state  = i_status.nxt;
                end
            end
        end
        if (cmd.load) n_out_valid = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_RIFF;
            r_out_valid <= 1'b0;
            r_last      <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_last      <= n_last;
        end
    end

    assign o_in_ready  = in_ready;
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // a new result never overwrites one that is still waiting
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten");

    // while dividing the result slot is empty
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !r_out_valid)
        else $error("result pending during divide");

    // a division start always leads into the divide wait
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.div_start |=> (r_state == ST_DIV))
        else $error("divide not entered");

    // a beat is never taken while dividing
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) |-> !cmd.take)
        else $error("beat taken during divide");
endmodule

// File: design/wav_pcm_stream_parser_top.sv
`timescale 1ns / 1ps

// channel   dir  beat
// i_in      in   byte_value, stream_end
// o_out     out  kind, error_code, sample_value, channel_index, frame_end,
//                data_end, channel_count, sample_rate, bits_per_sample, frame_total
//
// one byte per cycle, with a registered result slot that is refilled as it drains
// a data chunk header waits on the 32-step serial divider for frame_total
// synchronous active-low reset returns the parser to the riff header phase
// input is held off while a result waits unread or the divider runs

module wav_pcm_stream_parser_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    wpp_in_if.sink    i_in,
    wpp_out_if.source o_out
);
    import wpp_pkg::*;

    t_cmd    cmd;
    t_status status;
    t_result result;
    logic    in_ready;
    logic    out_valid;

    wpp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .i_in_last  (i_in.stream_end),
        .i_out_ready(o_out.ready),
        .i_status   (status),
        .o_in_ready (in_ready),
        .o_out_valid(out_valid),
        .o_cmd      (cmd)
    );

    wpp_dp u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_byte  (i_in.byte_value),
        .i_cmd   (cmd),
        .o_status(status),
        .o_result(result)
    );

    assign i_in.ready            = in_ready;
    assign o_out.valid           = out_valid;
    assign o_out.kind            = result.kind;
    assign o_out.error_code      = result.error_code;
    assign o_out.sample_value    = result.sample_value;
    assign o_out.channel_index   = result.channel_index;
    assign o_out.frame_end       = result.frame_end;
    assign o_out.data_end        = result.data_end;
    assign o_out.channel_count   = result.channel_count;
    assign o_out.sample_rate     = result.sample_rate;
    assign o_out.bits_per_sample = result.bits_per_sample;
    assign o_out.frame_total     = result.frame_total;
endmodule

// File: bench/tb_wav_pcm_stream_parser_top.sv
`timescale 1ns / 1ps

module tb_wav_pcm_stream_parser_top;
    import wpp_pkg::*;

    localparam int PH_RIFF  = 0;
    localparam int PH_CHUNK = 1;
    localparam int PH_FMT   = 2;
    localparam int PH_SKIP  = 3;
    localparam int PH_DATA  = 4;
    localparam int PH_DONE  = 5;
    localparam int IDLE_LIMIT = 3000;
    localparam logic [31:0] ID_LIST = 32'h5453_494C;

    class wav_scoreboard;
        int          phase;
        int unsigned pos;
        logic [31:0] id_word;
        logic [32:0] skip_left;
        bit          fmt_ok;
        logic [15:0] chans;
        logic [31:0] rate;
        logic [15:0] align;
        logic [15:0] vbits;
        int          nbytes;
        logic [31:0] acc;
        logic [15:0] chan_idx;
        logic [31:0] frames_left;
        bit          failed_file;
        logic [15:0] fcode;
        t_result     pending[$];
        int          errors;
        int          n_fmt, n_samples, n_err, n_eos;

        function new();
            clear();
            errors = 0;
            n_fmt = 0; n_samples = 0; n_err = 0; n_eos = 0;
        endfunction

        function void clear();
            phase = PH_RIFF; pos = 0; id_word = '0; skip_left = '0;
            fmt_ok = 0; chans = '0; rate = '0; align = '0; vbits = '0;
            nbytes = 0; acc = '0; chan_idx = '0; frames_left = '0;
            failed_file = 0; fcode = '0;
        endfunction

        function logic [31:0] ins_le(logic [31:0] w, int unsigned p, logic [7:0] b);
            int sh;
            sh = (p & 3) * 8;
            return (w & ~(32'hFF << sh)) | ({24'b0, b} << sh);
        endfunction

        function bit raise(t_err code, output t_result r);
            r = '0;
            r.kind = KIND_ERR;
            r.error_code = code;
            failed_file = 1;
            return 1;
        endfunction

        function bit check_fmt(output t_result r);
            int nb;
            r = '0;
            if (fcode != 16'd1) return raise(ERR_NOT_PCM, r);
            if (chans == 0) return raise(ERR_NO_CHAN, r);
            if (align == 0) return raise(ERR_ALIGN_ZERO, r);
            if (vbits < 2) return raise(ERR_BITS_LOW, r);
            if (vbits > 64) return raise(ERR_BITS_HIGH, r);
            nb = (vbits + 7) / 8;
            if (nb * chans != align) return raise(ERR_ALIGN_BAD, r);
            if (nb > MAX_SAMPLE_BYTES) return raise(ERR_TOO_WIDE, r);
            nbytes = nb;
            fmt_ok = 1;
            return 0;
        endfunction

        function bit header_done(output t_result r);
            logic [31:0] size;
            logic [32:0] padded;
            r = '0;
            size = skip_left[31:0];
            padded = {1'b0, size} + {32'b0, size[0]};
            pos = 0;
            if (id_word == ID_FMT) begin
                if (size < 16) return raise(ERR_FMT_SHORT, r);
                skip_left = padded - 33'd16;
                phase = PH_FMT;
                return 0;
            end
            if (id_word == ID_DATA) begin
                if (!fmt_ok) return raise(ERR_NO_FMT, r);
                if (size % align != 0) return raise(ERR_DATA_SIZE, r);
                frames_left = size / align;
                chan_idx = '0; acc = '0;
                r.kind = KIND_FMT;
                r.channel_count = chans;
                r.sample_rate = rate;
                r.bits_per_sample = vbits[6:0];
                r.frame_total = frames_left;
                phase = (frames_left != 0) ? PH_DATA : PH_DONE;
                return 1;
            end
            skip_left = padded;
            phase = (padded != 0) ? PH_SKIP : PH_CHUNK;
            return 0;
        endfunction

        function bit take(logic [7:0] b, output t_result r);
            int unsigned i;
            int nb;
            bit fe, de;
            logic [31:0] v;
            i = pos;
            r = '0;
            case (phase)
                PH_RIFF: begin
                    if (i < 4 || i >= 8) id_word = ins_le(id_word, i, b);
                    pos = i + 1;
                    if (i == 3 && id_word != ID_RIFF) return raise(ERR_RIFF_ID, r);
                    if (i == 11) begin
                        if (id_word != ID_WAVE) return raise(ERR_WAVE_ID, r);
                        pos = 0;
                        phase = PH_CHUNK;
                    end
                    return 0;
                end
                PH_CHUNK: begin
                    if (i < 4) id_word = ins_le(id_word, i, b);
                    else skip_left = {1'b0, ins_le(skip_left[31:0], i, b)};
                    pos = i + 1;
                    if (i == 7) return header_done(r);
                    return 0;
                end
                PH_FMT: begin
                    if (i < 2) fcode = 16'(ins_le({16'b0, fcode}, i, b));
                    else if (i < 4) chans = 16'(ins_le({16'b0, chans}, i - 2, b));
                    else if (i < 8) rate = ins_le(rate, i, b);
                    else if (i >= 12 && i < 14) align = 16'(ins_le({16'b0, align}, i, b));
                    else if (i >= 14) vbits = 16'(ins_le({16'b0, vbits}, i - 14, b));
                    pos = i + 1;
                    if (i == 15) begin
                        pos = 0;
                        if (check_fmt(r)) return 1;
                        phase = (skip_left != 0) ? PH_SKIP : PH_CHUNK;
                    end
                    return 0;
                end
                PH_SKIP: begin
                    if (skip_left != 0) skip_left = skip_left - 33'd1;
                    if (skip_left == 0) begin
                        phase = PH_CHUNK;
                        pos = 0;
                    end
                    return 0;
                end
                PH_DATA: begin
                    nb = (nbytes != 0) ? nbytes : 1;
                    acc = ins_le(acc, i, b);
                    if (i + 1 < nb) begin
                        pos = i + 1;
                        return 0;
                    end
                    pos = 0;
                    v = acc;
                    if (nb > 1 && nb < 4 && b[7]) v = v | (32'hFFFF_FFFF << (nb * 8));
                    acc = '0;
                    fe = ({16'b0, chan_idx} + 32'd1) >= {16'b0, chans};
                    de = fe && frames_left <= 1;
                    r.kind = KIND_SAMPLE;
                    r.sample_value = v;
                    r.channel_index = chan_idx;
                    r.frame_end = fe;
                    r.data_end = de;
                    if (fe) begin
                        chan_idx = '0;
                        if (frames_left != 0) frames_left = frames_left - 32'd1;
                    end else begin
                        chan_idx = chan_idx + 16'd1;
                    end
                    if (de) phase = PH_DONE;
                    return 1;
                end
                default: return 0;
            endcase
        endfunction

        function void note_byte(logic [7:0] b, bit last);
            t_result r;
            bit have;
            if (failed_file) begin
                if (last) clear();
                return;
            end
            have = take(b, r);
            if (last) begin
                if (!(have && r.kind == KIND_ERR)) begin
                    if (phase != PH_DONE) begin
                        r = '0;
                        r.kind = KIND_ERR;
                        r.error_code = ERR_EARLY_END;
                        have = 1;
                    end else if (!have) begin
                        r = '0;
                        r.kind = KIND_EOS;
                        have = 1;
                    end
                end
                clear();
            end
            if (have) pending.push_back(r);
        endfunction

        function void field(string name, logic [31:0] e, logic [31:0] a);
            if (e !== a) begin
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_result got);
            t_result e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result, actual kind %0d", $time, got.kind);
                errors++;
                return;
            end
            e = pending.pop_front();
            case (e.kind)
                KIND_FMT: n_fmt++;
                KIND_SAMPLE: n_samples++;
                KIND_ERR: n_err++;
                default: n_eos++;
            endcase
            field("kind", e.kind, got.kind);
            field("error_code", e.error_code, got.error_code);
            field("sample_value", e.sample_value, got.sample_value);
            field("channel_index", e.channel_index, got.channel_index);
            field("frame_end", e.frame_end, got.frame_end);
            field("data_end", e.data_end, got.data_end);
            field("channel_count", e.channel_count, got.channel_count);
            field("sample_rate", e.sample_rate, got.sample_rate);
            field("bits_per_sample", e.bits_per_sample, got.bits_per_sample);
            field("frame_total", e.frame_total, got.frame_total);
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    wpp_in_if  in_ch();
    wpp_out_if out_ch();

    wav_pcm_stream_parser_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    wav_scoreboard sb;
    logic [7:0] file_bytes[$];
    int burst_left;
    int idle_cycles;
    int bytes_sent;
    int files_sent;
    int stall_mode;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    function automatic void ap8(logic [7:0] b);
        file_bytes.push_back(b);
    endfunction

    function automatic void ap16(logic [15:0] v);
        ap8(v[7:0]); ap8(v[15:8]);
    endfunction

    function automatic void ap32(logic [31:0] v);
        ap16(v[15:0]); ap16(v[31:16]);
    endfunction

    function automatic void ap_rand(int n);
        for (int k = 0; k < n; k++) ap8(8'($urandom));
    endfunction

    // riff header, optional unknown chunk, optional fmt chunk, data chunk
    function automatic void build_wav(int fcode, int nch, int vbits, int align,
                                      int fmt_size, int dsize, int unk_len, bit with_fmt);
        file_bytes.delete();
        ap32(ID_RIFF); ap32($urandom); ap32(ID_WAVE);
        if (unk_len >= 0) begin
            ap32(ID_LIST); ap32(unk_len);
            ap_rand(unk_len + (unk_len & 1));
        end
        if (with_fmt) begin
            ap32(ID_FMT); ap32(fmt_size);
            if (fmt_size >= 16) begin
                ap16(16'(fcode)); ap16(16'(nch)); ap32($urandom);
                ap32($urandom); ap16(16'(align)); ap16(16'(vbits));
                ap_rand(fmt_size - 16 + (fmt_size & 1));
            end
        end
        ap32(ID_DATA); ap32(dsize);
        ap_rand(dsize);
    endfunction

    task automatic push_byte(logic [7:0] b, bit last);
        if (burst_left == 0) begin
            in_ch.valid = 1'b0;
            repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 6) : 0) @(negedge i_clk);
            burst_left = $urandom_range(1, 24);
        end
        in_ch.valid = 1'b1;
        in_ch.byte_value = b;
        in_ch.stream_end = last;
        do @(posedge i_clk); while (!in_ch.ready);
        sb.note_byte(b, last);
        bytes_sent++;
        @(negedge i_clk);
        in_ch.valid = 1'b0;
        burst_left--;
    endtask

    task automatic send_file(int cut, int trail);
        int n;
        n = file_bytes.size() - cut;
        if (n < 1) n = 1;
        for (int k = 0; k < trail; k++) file_bytes.insert(n + k, 8'($urandom));
        n = n + trail;
        for (int k = 0; k < n; k++) push_byte(file_bytes[k], k == n - 1);
        files_sent++;
    endtask

    task automatic random_file();
        int pick, nch, vbits, nb, frames, fsz, unk;
        pick = $urandom_range(0, 99);
        if (pick < 10) begin
            file_bytes.delete();
            ap_rand($urandom_range(1, 30));
            send_file(0, 0);
            return;
        end
        nch = $urandom_range(1, 3);
        vbits = $urandom_range(2, 32);
        nb = (vbits + 7) / 8;
        frames = $urandom_range(0, 4);
        fsz = 16 + $urandom_range(0, 3);
        unk = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 5) : -1;
        build_wav(1, nch, vbits, nb * nch, fsz, frames * nb * nch, unk, 1);
        if (pick < 25) file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
        if (pick >= 90) send_file($urandom_range(1, 6), 0);
        else send_file(0, ($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0);
    endtask

    // receiver stall pattern changes at random times
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready = 1'b0;
        end else begin
            if ($urandom_range(0, 127) == 0) stall_mode = $urandom_range(0, 2);
            case (stall_mode)
                0: out_ch.ready = 1'b1;
                1: out_ch.ready = $urandom_range(0, 1);
                default: out_ch.ready = ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        t_result got;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            got.kind = t_kind'(out_ch.kind);
            got.error_code = t_err'(out_ch.error_code);
            got.sample_value = out_ch.sample_value;
            got.channel_index = out_ch.channel_index;
            got.frame_end = out_ch.frame_end;
            got.data_end = out_ch.data_end;
            got.channel_count = out_ch.channel_count;
            got.sample_rate = out_ch.sample_rate;
            got.bits_per_sample = out_ch.bits_per_sample;
            got.frame_total = out_ch.frame_total;
            sb.check_result(got);
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || !i_rst_n) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("wav_pcm_stream_parser_top test failed");
                $finish;
            end
        end
    end

    initial begin
        sb = new();
        in_ch.valid = 1'b0;
        in_ch.byte_value = '0;
        in_ch.stream_end = 1'b0;
        burst_left = 0; idle_cycles = 0; bytes_sent = 0; files_sent = 0; stall_mode = 0;
        i_rst_n = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // good files across sample widths, odd unknown chunk, padded fmt, trailing bytes; then data with no fmt
        build_wav(1, 2, 16, 4, 18, 8, 3, 1);   send_file(0, 2);
        build_wav(1, 1, 8, 1, 16, 3, -1, 1);   send_file(0, 0);
        build_wav(1, 2, 24, 6, 16, 6, -1, 1);  send_file(0, 0);
        build_wav(1, 1, 32, 4, 17, 8, 0, 1);   send_file(0, 0);
        build_wav(1, 3, 12, 6, 16, 0, -1, 1);  send_file(0, 0);
        file_bytes.delete();
        ap32(ID_RIFF); ap32(0); ap32(ID_WAVE); ap32(ID_DATA); ap32(4);
        ap32(32'hFFFF_FFFF); ap16(16'h80FF); ap16(16'h7F00); ap16(16'd0);
        send_file(0, 0);
        // header errors
        file_bytes.delete(); ap32(32'h0000_00FF); ap_rand(4); send_file(0, 0);
        file_bytes.delete(); ap32(ID_RIFF); ap32(0); ap32(ID_FMT); ap_rand(3); send_file(0, 0);
        // fmt errors
        build_wav(1, 1, 8, 1, 15, 1, -1, 1);   send_file(0, 0);
        build_wav(3, 1, 8, 1, 16, 1, -1, 1);   send_file(0, 0);
        build_wav(1, 0, 8, 1, 16, 1, -1, 1);   send_file(0, 0);
        build_wav(1, 1, 8, 0, 16, 1, -1, 1);   send_file(0, 0);
        build_wav(1, 1, 1, 1, 16, 1, -1, 1);   send_file(0, 0);
        build_wav(1, 1, 65, 9, 16, 9, -1, 1);  send_file(0, 0);
        build_wav(1, 2, 16, 3, 16, 3, -1, 1);  send_file(0, 0);
        build_wav(1, 1, 64, 8, 16, 8, -1, 1);  send_file(0, 0);
        // data errors, truncation
        build_wav(1, 1, 8, 1, 16, 2, -1, 0);   send_file(0, 0);
        build_wav(1, 2, 16, 4, 16, 6, -1, 1);  send_file(0, 0);
        build_wav(1, 1, 16, 2, 16, 8, -1, 1);  send_file(3, 0);
        file_bytes.delete(); ap8(8'h00); send_file(0, 0);

        while (bytes_sent < 700) random_file();

        while (sb.pending.size() != 0) @(posedge i_clk);
        repeat (60) @(posedge i_clk);
        $display("%0d files, %0d bytes: %0d format, %0d sample, %0d error, %0d end results",
                 files_sent, bytes_sent, sb.n_fmt, sb.n_samples, sb.n_err, sb.n_eos);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("wav_pcm_stream_parser_top test passed");
        end else begin
            $display("wav_pcm_stream_parser_top test failed");
        end
        $finish;
    end

endmodule
